// File: hdl/spp_pkg.sv
`default_nettype none

package spp_pkg;

    // Field widths fixed by the item formats
    localparam int unsigned CNT_W     = 16;
    localparam int unsigned AMOUNT_W  = 8;
    localparam int unsigned PENDING_W = 32;

    // Configuration port
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned REG_IDX_W  = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PULSE_PERIOD_TOP = 2'd0,
        REG_PULSE_HIGH_TICKS = 2'd1,
        REG_GROUP_TOP        = 2'd2,
        REG_UNUSED           = 2'd3
    } t_reg_idx;

    localparam logic [CNT_W-1:0] PULSE_PERIOD_TOP_RST = 16'd999;
    localparam logic [CNT_W-1:0] PULSE_HIGH_TICKS_RST = 16'd500;
    localparam logic [CNT_W-1:0] GROUP_TOP_RST        = 16'd1;

    // Item action codes
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic                       action;
        logic signed [AMOUNT_W-1:0] step_amount;
        logic                       forward_end_hit;
        logic                       reverse_end_hit;
    } t_in_item;

    typedef struct packed {
        logic                        step_out;
        logic                        direction_out;
        logic                        is_running;
        logic signed [PENDING_W-1:0] steps_pending;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0] pulse_period_top;
        logic [CNT_W-1:0] pulse_high_ticks;
        logic [CNT_W-1:0] group_top;
    } t_cfg;

endpackage

`default_nettype wire

// File: hdl/spp_core.sv
`default_nettype none

module spp_core
    import spp_pkg::*;
#(
    parameter int unsigned POOL_WIDTH = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_accept,
    input  wire t_in_item  i_item,
    input  wire t_cfg      i_cfg,
    output t_out_item      o_result
);

    localparam logic signed [POOL_WIDTH-1:0] POOL_MAX = {1'b0, {(POOL_WIDTH-1){1'b1}}};
    localparam logic signed [POOL_WIDTH-1:0] POOL_MIN = {1'b1, {(POOL_WIDTH-1){1'b0}}};
    localparam logic signed [POOL_WIDTH-1:0] POOL_ONE = POOL_WIDTH'(1);

    logic signed [POOL_WIDTH-1:0] r_pool, n_pool;
    logic                         r_dir, n_dir;
    logic                         r_run, n_run;
    logic [CNT_W-1:0]             r_pulse_cnt, n_pulse_cnt;
    logic [CNT_W-1:0]             r_group_cnt, n_group_cnt;

    logic signed [POOL_WIDTH:0]   w_sum;
    logic signed [POOL_WIDTH-1:0] w_sat;
    logic signed [POOL_WIDTH-1:0] w_toward_zero;

    // Saturating add of the step amount, one bit of headroom
    always_comb begin
        w_sum = (POOL_WIDTH+1)'(r_pool) + (POOL_WIDTH+1)'(i_item.step_amount);
        if (w_sum[POOL_WIDTH] != w_sum[POOL_WIDTH-1]) begin
            w_sat = w_sum[POOL_WIDTH] ? POOL_MIN : POOL_MAX;
        end else begin
            w_sat = w_sum[POOL_WIDTH-1:0];
        end
    end

    // Move one count toward zero
    always_comb begin
        if (r_pool == '0) begin
            w_toward_zero = r_pool;
        end else if (r_pool[POOL_WIDTH-1]) begin
            w_toward_zero = r_pool + POOL_ONE;
        end else begin
            w_toward_zero = r_pool - POOL_ONE;
        end
    end

    always_comb begin
        n_pool      = r_pool;
        n_dir       = r_dir;
        n_run       = r_run;
        n_pulse_cnt = r_pulse_cnt;
        n_group_cnt = r_group_cnt;
        if (i_item.action == ACT_ADD) begin
            n_pool = w_sat;
            n_dir  = w_sat[POOL_WIDTH-1];
            if (w_sat != '0) begin
                if (w_sat[POOL_WIDTH-1] ? i_item.reverse_end_hit
                                        : i_item.forward_end_hit) begin
                    n_pool = '0;
                end else begin
                    n_run = 1'b1;
                end
            end
        end else if (r_run) begin
            if (r_pulse_cnt >= i_cfg.pulse_period_top) begin
                n_pulse_cnt = '0;
                if (r_group_cnt >= i_cfg.group_top) begin
                    n_group_cnt = '0;
                    n_pool      = w_toward_zero;
                    if (w_toward_zero == '0) begin
                        n_run = 1'b0;
                    end
                end else begin
                    n_group_cnt = r_group_cnt + CNT_W'(1);
                end
            end else begin
                n_pulse_cnt = r_pulse_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool      <= '0;
            r_dir       <= 1'b0;
            r_run       <= 1'b0;
            r_pulse_cnt <= '0;
            r_group_cnt <= '0;
        end else if (i_accept) begin
            r_pool      <= n_pool;
            r_dir       <= n_dir;
            r_run       <= n_run;
            r_pulse_cnt <= n_pulse_cnt;
            r_group_cnt <= n_group_cnt;
        end
    end

    // Result reflects the state after the item
    always_comb begin
        o_result.step_out      = n_run && (n_pulse_cnt < i_cfg.pulse_high_ticks);
        o_result.direction_out = n_dir;
        o_result.is_running    = n_run;
        o_result.steps_pending = PENDING_W'(n_pool);
    end

endmodule

`default_nettype wire

// File: hdl/step_pool_pulse_controller_top.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_data  (t_in_item)
// result    out        o_out_valid / i_out_ready  o_out_data (t_out_item)
// config    in         APB psel/penable/pwrite    paddr, pwdata, prdata
//
// Every item (add or tick) is one state update: a single saturating
// add, a step of one toward zero and two 16-bit counter compares.
// One beat per cycle is sustained; a two-entry result queue holds results
// while the consumer stalls, and o_in_ready drops only when both are full.
// Reset (i_rst_n low at a clock edge) clears the pool, flags, counters and
// the queue, and loads the register defaults; no clearing pass is needed.

module step_pool_pulse_controller_top
    import spp_pkg::*;
#(
    parameter int unsigned POOL_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_cfg     r_cfg;
    t_reg_idx w_reg_idx;
    logic     w_cfg_write;

    assign pready      = 1'b1;
    assign w_reg_idx   = t_reg_idx'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_period_top <= PULSE_PERIOD_TOP_RST;
            r_cfg.pulse_high_ticks <= PULSE_HIGH_TICKS_RST;
            r_cfg.group_top        <= GROUP_TOP_RST;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                REG_PULSE_PERIOD_TOP: r_cfg.pulse_period_top <= pwdata[CNT_W-1:0];
                REG_PULSE_HIGH_TICKS: r_cfg.pulse_high_ticks <= pwdata[CNT_W-1:0];
                REG_GROUP_TOP:        r_cfg.group_top        <= pwdata[CNT_W-1:0];
                default: ; // drop writes outside the register map
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_reg_idx)
            REG_PULSE_PERIOD_TOP: prdata = APB_DATA_W'(r_cfg.pulse_period_top);
            REG_PULSE_HIGH_TICKS: prdata = APB_DATA_W'(r_cfg.pulse_high_ticks);
            REG_GROUP_TOP:        prdata = APB_DATA_W'(r_cfg.group_top);
            default:              prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Step pool state and pulse counters
    // ---------------------------------------------------------------
    logic      w_in_accept;
    t_out_item w_result;

    assign w_in_accept = i_in_valid && o_in_ready;

    spp_core #(
        .POOL_WIDTH (POOL_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_accept),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // ---------------------------------------------------------------
    // Result queue: output register plus skid entry
    // ---------------------------------------------------------------
    t_out_item r_out;
    t_out_item r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;
    logic      w_out_take;

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_take  = r_out_valid && i_out_ready;

    // Control: advance skid into the output slot when the consumer takes a beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_accept) begin
            if (r_out_valid && !w_out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out <= r_skid;
            end
        end else if (w_in_accept) begin
            if (r_out_valid && !w_out_take) begin
                r_skid <= w_result;
            end else begin
                r_out <= w_result;
            end
        end
    end

endmodule

`default_nettype wire

// File: dv/tb_step_pool_pulse_controller_top.sv
module tb_step_pool_pulse_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spp_pkg::*;

    // Quiet cycles before the watchdog gives up: longest sender gap plus the
    // longest receiver stall plus a few register writes fit many times over.
    localparam int unsigned IDLE_LIMIT      = 5000;
    localparam int unsigned MAX_CYCLES      = 2_000_000;
    localparam int unsigned NUM_PHASES      = 8;
    localparam int unsigned ITEMS_PER_PHASE = 125;
    localparam int unsigned REPORT_LIMIT    = 10;

    // Saturation limits of the 32-bit step pool
    localparam longint POOL_HI = longint'(32'h7fff_ffff);
    localparam longint POOL_LO = -POOL_HI - 1;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;

    logic                  in_valid  = 1'b0;
    t_in_item              in_beat   = '0;
    logic                  o_in_ready;

    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             o_out_data;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    always #4 i_clk = ~i_clk;

    step_pool_pulse_controller_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Motor model: pool, direction, run flag, counters and registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] cfg_period = PULSE_PERIOD_TOP_RST;
    logic [CNT_W-1:0] cfg_high   = PULSE_HIGH_TICKS_RST;
    logic [CNT_W-1:0] cfg_group  = GROUP_TOP_RST;

    longint           pool          = 0;
    logic             motor_reverse = 1'b0;
    logic             running       = 1'b0;
    logic [CNT_W-1:0] pulse_cnt     = '0;
    logic [CNT_W-1:0] group_cnt     = '0;

    t_in_item    pending_items_q[$];
    t_out_item   expected_status_q[$];
    int unsigned items_queued   = 0;
    int unsigned beats_accepted = 0;
    int unsigned mismatches     = 0;

    // Idle switches, set per phase while nothing is in flight
    bit sender_idles   = 1'b0;
    bit receiver_idles = 1'b0;

    // Advance the motor model by one beat and queue the status it leaves.
    function automatic void predict_status(input t_in_item beat);
        longint    amount;
        longint    sum;
        t_out_item status;
        if (beat.action == ACT_ADD) begin
            amount = longint'($signed(beat.step_amount));
            sum    = pool + amount;
            if (sum > POOL_HI) begin
                sum = POOL_HI;
            end else if (sum < POOL_LO) begin
                sum = POOL_LO;
            end
            pool          = sum;
            motor_reverse = (pool < 0);
            // Only the sensor on the side of travel matters; a zero pool
            // leaves the run flag alone so a running group can finish.
            if (pool > 0) begin
                if (beat.forward_end_hit) pool = 0;
                else running = 1'b1;
            end else if (pool < 0) begin
                if (beat.reverse_end_hit) pool = 0;
                else running = 1'b1;
            end
        end else if (running) begin
            // Counters compare with >= so a lowered top wraps on next advance
            if (pulse_cnt >= cfg_period) begin
                pulse_cnt = '0;
                if (group_cnt >= cfg_group) begin
                    group_cnt = '0;
                    if (pool > 0) pool--;
                    else if (pool < 0) pool++;
                    if (pool == 0) running = 1'b0;
                end else begin
                    group_cnt++;
                end
            end else begin
                pulse_cnt++;
            end
        end
        status.step_out      = running && (pulse_cnt < cfg_high);
        status.direction_out = motor_reverse;
        status.is_running    = running;
        status.steps_pending = PENDING_W'(pool);
        expected_status_q.push_back(status);
    endfunction

    function automatic t_in_item make_item(input logic action, input logic [AMOUNT_W-1:0] amount,
                                           input logic fwd, input logic rev);
        t_in_item it;
        it.action          = action;
        it.step_amount     = amount;
        it.forward_end_hit = fwd;
        it.reverse_end_hit = rev;
        return it;
    endfunction

    // Mostly ticks so groups complete; adds are mostly small so the pool
    // keeps crossing zero, with a share of extremes and full-range amounts.
    function automatic t_in_item random_motor_item();
        t_in_item    it;
        int unsigned pick;
        it.action = ($urandom_range(0, 99) < 70) ? ACT_TICK : ACT_ADD;
        pick = $urandom_range(0, 9);
        if (it.action == ACT_ADD && pick < 6) begin
            it.step_amount = AMOUNT_W'($urandom_range(0, 8) - 4);
        end else if (pick == 6) begin
            it.step_amount = $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
        end else begin
            it.step_amount = AMOUNT_W'($urandom);
        end
        it.forward_end_hit = ($urandom_range(0, 99) < 15);
        it.reverse_end_hit = ($urandom_range(0, 99) < 15);
        return it;
    endfunction

    // Mostly short idle stretches, now and then a long one
    function automatic int unsigned pick_idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued beats, hold each until taken, idle at random
    // ------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            // Predict on the beat that the block takes at this edge
            if (in_valid && o_in_ready) begin
                predict_status(in_beat);
                beats_accepted++;
            end
            // Hold the payload while a beat waits; otherwise load the next
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items_q.size() > 0) begin
                    in_beat  <= pending_items_q.pop_front();
                    in_valid <= 1'b1;
                    if (sender_idles && $urandom_range(0, 99) < 20) send_gap = pick_idle_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest expected status
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result beat with nothing expected: %p", $time, o_out_data);
                end else begin
                    want = expected_status_q.pop_front();
                    if (o_out_data.step_out      !== want.step_out      ||
                        o_out_data.direction_out !== want.direction_out ||
                        o_out_data.is_running    !== want.is_running    ||
                        o_out_data.steps_pending !== want.steps_pending) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: status mismatch exp step=%0b dir=%0b run=%0b pend=%0d",
                                     $time, want.step_out, want.direction_out, want.is_running,
                                     want.steps_pending, "\n    got step=%0b dir=%0b run=%0b pend=%0d",
                                     o_out_data.step_out, o_out_data.direction_out,
                                     o_out_data.is_running, o_out_data.steps_pending);
                    end
                end
            end
            // Drop ready at random when the receiver is allowed to stall
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (receiver_idles && $urandom_range(0, 99) < 15) begin
                stall_left = pick_idle_len() - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no beat moves for too long
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;
    int unsigned cycles_run   = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycles_run++;
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT || cycles_run >= MAX_CYCLES) begin
                $display("%0t: watchdog expired, %0d beats still expected",
                         $time, expected_status_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: register writes, directed beats, random phases
    // ------------------------------------------------------------------
    task automatic queue_item(input t_in_item it);
        pending_items_q.push_back(it);
        items_queued++;
    endtask

    // Wait until every queued beat is taken and every status has returned
    task automatic wait_for_drain();
        while (beats_accepted != items_queued || expected_status_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where the access completes, so update the model there.
    task automatic cfg_write(input t_reg_idx idx, input logic [CNT_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PULSE_PERIOD_TOP: cfg_period = value;
            REG_PULSE_HIGH_TICKS: cfg_high   = value;
            REG_GROUP_TOP:        cfg_group  = value;
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [CNT_W-1:0] period, input logic [CNT_W-1:0] high,
                              input logic [CNT_W-1:0] group);
        cfg_write(REG_PULSE_PERIOD_TOP, period);
        cfg_write(REG_PULSE_HIGH_TICKS, high);
        cfg_write(REG_GROUP_TOP, group);
    endtask

    initial begin
        int unsigned p;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats on a short pulse so groups end within a few ticks
        set_limits(16'd3, 16'd2, 16'd1);
        queue_item(make_item(ACT_TICK, 8'hff, 1'b1, 1'b1));   // tick while idle
        queue_item(make_item(ACT_ADD, 8'h00, 1'b1, 1'b1));    // add nothing to empty pool
        queue_item(make_item(ACT_ADD, 8'h7f, 1'b0, 1'b1));    // largest add, reverse sensor ignored
        repeat (5) queue_item(make_item(ACT_TICK, 8'h80, 1'b1, 1'b0));
        queue_item(make_item(ACT_ADD, 8'h80, 1'b1, 1'b0));    // smallest add, pool goes negative
        queue_item(make_item(ACT_ADD, 8'h01, 1'b0, 1'b0));    // reach zero while running
        repeat (8) queue_item(make_item(ACT_TICK, 8'h55, 1'b0, 1'b1));  // group ends, stops
        queue_item(make_item(ACT_ADD, 8'h05, 1'b1, 1'b0));    // forward sensor clears pool
        queue_item(make_item(ACT_ADD, 8'hfb, 1'b0, 1'b1));    // reverse sensor clears pool
        queue_item(make_item(ACT_ADD, 8'hfd, 1'b1, 1'b0));    // reverse travel starts
        repeat (4) queue_item(make_item(ACT_TICK, 8'haa, 1'b1, 1'b1));
        wait_for_drain();

        // Random phases; each drains fully before the registers change, and
        // a large top followed by a small one leaves counters above top.
        for (p = 0; p < NUM_PHASES; p++) begin
            sender_idles   = p[0];
            receiver_idles = p[1];
            case (p)
                0: set_limits(16'd1, 16'd1, 16'd0);
                1: set_limits(16'hffff, 16'hffff, 16'hffff);
                2: set_limits(16'd2, 16'd0, 16'd0);
                3: set_limits(16'd5, 16'd3, 16'd2);
                5: set_limits(16'd3, 16'hffff, 16'd1);
                6: set_limits(CNT_W'($urandom_range(1, 65535)), CNT_W'($urandom),
                              CNT_W'($urandom));
                default: set_limits(CNT_W'($urandom_range(1, 8)), CNT_W'($urandom_range(0, 10)),
                                    CNT_W'($urandom_range(0, 3)));
            endcase
            repeat (ITEMS_PER_PHASE) queue_item(random_motor_item());
            wait_for_drain();
        end

        // Let any stray result beat show up before the verdict
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_status_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: step_pool_pulse_controller_top.f
hdl/spp_pkg.sv
hdl/spp_core.sv
hdl/step_pool_pulse_controller_top.sv
dv/tb_step_pool_pulse_controller_top.sv
